FILE: sv/call_tree_profiler_assert.svh
// ---------------------------------------------------------------------------
// call_tree_profiler_assert.svh
// Assertion macros shared by the call tree profiler checkers.
// ---------------------------------------------------------------------------
`ifndef CALL_TREE_PROFILER_ASSERT_SVH
`define CALL_TREE_PROFILER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define CTP_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CTP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, always active (reset behavior)
`define CTP_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ctp_pkg.sv
// ---------------------------------------------------------------------------
// ctp_pkg
// Shared types, codes and constants of the call tree profiler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctp_pkg;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int TAG_W     = 16;
  localparam int STAMP_W   = 16;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 6;

  // Parameter defaults
  localparam int NODE_COUNT_DEF  = 64;
  localparam int CHILD_LIMIT_DEF = 8;
  localparam int TAG_BITS_DEF    = 16;

  // Event codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_IGNORE  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_CHILD_FULL = 2'd2,
    ST_POP_ROOT   = 2'd3
  } status_t;

  // Input word
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] timestamp;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] charged_node;
    logic [TIME_W-1:0]    charged_total;
    logic [OUT_IDX_W-1:0] current_index;
    logic                 created;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch input word
    logic capture;   // take node reads, form the charged total
    logic slot_inc;  // advance to the next child slot
    logic cmp;       // compare child tag
    logic commit;    // apply the event to the tree
    logic alloc;     // zero the new node's total and child count
    logic clr_root;  // zero the root entry after reset
    logic load_out;  // load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              more_slots;
    logic              tag_hit;
    logic              need_alloc;
  } ctl_stat_t;

endpackage

FILE: sv/call_tree_profiler.sv
// ---------------------------------------------------------------------------
// call_tree_profiler
// Call tree profiler: charges elapsed time to the current node and walks
// or grows the tree on push and pop words.
//
//   channel  dir  word        handshake
//   in_      in   in_word_t   in_valid / in_ready
//   out_     out  out_word_t  out_valid / out_ready
//
// One word at a time. Pop and restart pass READ, COMMIT and OUT; mode three
// passes READ and OUT. A push searches its children through TRD and CMP, with
// CRD before each further child, as the child and tag tables have registered
// reads; COMMIT is followed by ALLOC when a node is allocated.
// After reset the INIT state clears the root entry before in_ready rises.
// A result waiting in the output register does not block taking the next word,
// only loading its result in OUT.
`timescale 1ns / 1ps

module call_tree_profiler #(
  parameter int NODE_COUNT  = ctp_pkg::NODE_COUNT_DEF,
  parameter int CHILD_LIMIT = ctp_pkg::CHILD_LIMIT_DEF,
  parameter int TAG_BITS    = ctp_pkg::TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output ctp_pkg::out_word_t out_word
);

  ctp_pkg::ctl_cmd_t  cmd;
  ctp_pkg::ctl_stat_t stat;

  // Sequencer
  ctp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Tables and registers
  ctp_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .CHILD_LIMIT (CHILD_LIMIT),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

FILE: sv/ctp_datapath.sv
// ---------------------------------------------------------------------------
// ctp_datapath
// Node tables, current-node registers and result register of the profiler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_datapath #(
  parameter int NODE_COUNT  = ctp_pkg::NODE_COUNT_DEF,
  parameter int CHILD_LIMIT = ctp_pkg::CHILD_LIMIT_DEF,
  parameter int TAG_BITS    = ctp_pkg::TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctp_pkg::in_word_t   in_word,
  input  ctp_pkg::ctl_cmd_t   cmd,
  output ctp_pkg::ctl_stat_t  stat,
  output ctp_pkg::out_word_t  out_word
);

  localparam int IW  = $clog2(NODE_COUNT);
  localparam int NUW = $clog2(NODE_COUNT + 1);
  localparam int CW  = $clog2(CHILD_LIMIT + 1);
  localparam int SW  = (CHILD_LIMIT > 1) ? $clog2(CHILD_LIMIT) : 1;
  localparam int TW  = (TAG_BITS < ctp_pkg::TAG_W) ? TAG_BITS : ctp_pkg::TAG_W;
  localparam int CHILD_DEPTH = NODE_COUNT * (1 << SW);
  localparam int TW_ = ctp_pkg::TIME_W;

  // Node tables
  logic [TW_-1:0] time_mem  [NODE_COUNT];
  logic [CW-1:0]  count_mem [NODE_COUNT];
  logic [IW-1:0]  parent_mem[NODE_COUNT];
  logic [TW-1:0]  tag_mem   [NODE_COUNT];
  logic [IW-1:0]  child_mem [CHILD_DEPTH];

  // Registered read data
  logic [TW_-1:0] time_q;
  logic [CW-1:0]  count_q;
  logic [IW-1:0]  parent_q;
  logic [IW-1:0]  child_q;
  logic [TW-1:0]  tag_q;

  // Event and tree registers
  logic [ctp_pkg::MODE_W-1:0]   mode_r;
  logic [TW-1:0]                tag_r;
  logic [ctp_pkg::STAMP_W-1:0]  stamp_r;
  logic [ctp_pkg::STAMP_W-1:0]  prev_r;
  logic [IW-1:0]                cur_r;
  logic [NUW-1:0]               nodes_used_r;
  logic [IW-1:0]                charged_r;
  logic [TW_-1:0]               total_r;
  logic [CW-1:0]                cnt_r;
  logic [IW-1:0]                parent_r;
  logic [SW-1:0]                slot_r;
  logic                         found_r;
  logic [IW-1:0]                next_r;
  logic [ctp_pkg::STATUS_W-1:0] status_r;
  logic                         created_r;
  ctp_pkg::out_word_t           out_word_r;

  logic [ctp_pkg::STAMP_W-1:0] elapsed;
  logic                        table_full;
  logic                        list_full;
  logic [IW-1:0]               new_idx;
  logic [CW:0]                 slot_next;
  logic                        restart;
  logic                        need_alloc;

  // Time/count write port
  logic           time_we;
  logic [IW-1:0]  time_wa;
  logic [TW_-1:0] time_wd;
  logic           count_we;
  logic [CW-1:0]  count_wd;

  assign elapsed    = stamp_r - prev_r;
  assign table_full = (nodes_used_r >= NUW'(NODE_COUNT));
  assign list_full  = (cnt_r >= CW'(CHILD_LIMIT));
  assign new_idx    = nodes_used_r[IW-1:0];
  assign slot_next  = (CW+1)'(slot_r) + (CW+1)'(1);
  assign restart    = (mode_r == ctp_pkg::MODE_RESTART);
  assign need_alloc = (mode_r == ctp_pkg::MODE_PUSH) && !found_r && !table_full && !list_full;

  // Status to controller
  assign stat.mode       = mode_r;
  assign stat.cnt_zero   = (count_q == '0);
  assign stat.more_slots = (slot_next < (CW+1)'(cnt_r));
  assign stat.tag_hit    = (tag_q == tag_r);
  assign stat.need_alloc = need_alloc;

  // Write port selection for the per-node totals and child counts
  always_comb begin
    time_we  = 1'b0;
    time_wa  = cur_r;
    time_wd  = total_r;
    count_we = 1'b0;
    count_wd = cnt_r + CW'(1);
    if (cmd.clr_root || (cmd.commit && restart)) begin
      time_we  = 1'b1;
      time_wa  = '0;
      time_wd  = '0;
      count_we = 1'b1;
      count_wd = '0;
    end else if (cmd.commit) begin
      time_we  = 1'b1;
      count_we = need_alloc;
    end else if (cmd.alloc) begin
      time_we  = 1'b1;
      time_wd  = '0;
      count_we = 1'b1;
      count_wd = '0;
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[time_wa] <= time_wd;
    end
    if (count_we) begin
      count_mem[time_wa] <= count_wd;
    end
    if (cmd.commit && need_alloc) begin
      child_mem[{cur_r, cnt_r[SW-1:0]}] <= new_idx;
      parent_mem[new_idx]              <= cur_r;
      tag_mem[new_idx]                 <= tag_r;
    end
  end

  // Memory reads: current node entry, child slot, then that child's tag
  always_ff @(posedge clk) begin
    time_q   <= time_mem[cur_r];
    count_q  <= count_mem[cur_r];
    parent_q <= parent_mem[cur_r];
    child_q  <= child_mem[{cur_r, slot_r}];
    tag_q    <= tag_mem[child_q];
  end

  // Tree state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      nodes_used_r <= NUW'(1);
      prev_r       <= '0;
    end else if (cmd.commit) begin
      prev_r <= stamp_r;
      if (restart) begin
        cur_r        <= '0;
        nodes_used_r <= NUW'(1);
      end else if (mode_r == ctp_pkg::MODE_POP) begin
        if (cur_r != '0) begin
          cur_r <= parent_r;
        end
      end else if (found_r) begin
        cur_r <= next_r;
      end else if (need_alloc) begin
        cur_r        <= new_idx;
        nodes_used_r <= nodes_used_r + NUW'(1);
      end
    end
  end

  // Per-event working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r    <= in_word.mode;
      tag_r     <= in_word.tag[TW-1:0];
      stamp_r   <= in_word.timestamp;
      charged_r <= cur_r;
      slot_r    <= '0;
      found_r   <= 1'b0;
      status_r  <= ctp_pkg::ST_OK;
      created_r <= 1'b0;
    end
    if (cmd.capture) begin
      cnt_r    <= count_q;
      parent_r <= parent_q;
      case (mode_r)
        ctp_pkg::MODE_PUSH,
        ctp_pkg::MODE_POP:     total_r <= time_q + TW_'(elapsed);
        ctp_pkg::MODE_RESTART: total_r <= '0;
        default:               total_r <= time_q;
      endcase
    end
    if (cmd.slot_inc) begin
      slot_r <= slot_next[SW-1:0];
    end
    if (cmd.cmp && stat.tag_hit) begin
      found_r <= 1'b1;
      next_r  <= child_q;
    end
    if (cmd.commit) begin
      if (restart) begin
        charged_r <= '0;
      end else if (mode_r == ctp_pkg::MODE_POP) begin
        if (cur_r == '0) begin
          status_r <= ctp_pkg::ST_POP_ROOT;
        end
      end else if (!found_r) begin
        if (table_full) begin
          status_r <= ctp_pkg::ST_TABLE_FULL;
        end else if (list_full) begin
          status_r <= ctp_pkg::ST_CHILD_FULL;
        end else begin
          created_r <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.status        <= status_r;
      out_word_r.charged_node  <= ctp_pkg::OUT_IDX_W'(charged_r);
      out_word_r.charged_total <= total_r;
      out_word_r.current_index <= ctp_pkg::OUT_IDX_W'(cur_r);
      out_word_r.created       <= created_r;
    end
  end

  assign out_word = out_word_r;

endmodule

FILE: sv/ctp_ctrl.sv
// ---------------------------------------------------------------------------
// ctp_ctrl
// Event sequencer of the profiler: read, child search, update, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ctp_pkg::ctl_stat_t stat,
  output ctp_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_READ   = 9'b000000100,
    S_CRD    = 9'b000001000,
    S_TRD    = 9'b000010000,
    S_CMP    = 9'b000100000,
    S_COMMIT = 9'b001000000,
    S_ALLOC  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_INIT: begin
        cmd.clr_root = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        case (stat.mode)
          ctp_pkg::MODE_PUSH:    state_nxt = stat.cnt_zero ? S_COMMIT : S_TRD;
          ctp_pkg::MODE_POP,
          ctp_pkg::MODE_RESTART: state_nxt = S_COMMIT;
          default:               state_nxt = S_OUT;
        endcase
      end
      S_CRD: begin
        state_nxt = S_TRD;
      end
      S_TRD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.tag_hit) begin
          state_nxt = S_COMMIT;
        end else if (stat.more_slots) begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_CRD;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = stat.need_alloc ? S_ALLOC : S_OUT;
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/ctp_checker.sv
// ---------------------------------------------------------------------------
// ctp_checker
// Port-level checks of the call tree profiler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "call_tree_profiler_assert.svh"

module ctp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ctp_pkg::out_word_t out_word
);

  // Stalled result word holds
  `CTP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // No result comes out of reset
  `CTP_ASSERT_RST(a_rst_quiet, clk, !rst_n, !out_valid, "result valid after reset")

  // One word in flight: a taken word closes the input
  `CTP_ASSERT_NXT(a_one_word, clk, rst_n, in_valid && in_ready, !in_ready, "input ready right after accept")

  // Pop at the root leaves and charges the root
  `CTP_ASSERT_IMM(a_pop_root, clk, rst_n, out_valid && out_word.status == ctp_pkg::ST_POP_ROOT, out_word.current_index == '0 && out_word.charged_node == '0 && !out_word.created, "pop at root moved off the root")

  // A refused push keeps the current node
  `CTP_ASSERT_IMM(a_refused, clk, rst_n, out_valid && (out_word.status == ctp_pkg::ST_TABLE_FULL || out_word.status == ctp_pkg::ST_CHILD_FULL), out_word.current_index == out_word.charged_node && !out_word.created, "refused push changed the tree")

endmodule

bind call_tree_profiler ctp_checker u_ctp_checker (.*);
